### rtl/core/ipv4hv_pkg.sv
// ----------------------------------------------------------------------------
// ipv4hv_pkg
// shared types, codes and helpers of the ipv4 header validator
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4hv_pkg;

    localparam int WORD_W   = 16;
    localparam int POS_W    = 5;
    localparam int HWORDS_W = 5;
    localparam int HBYTES_W = 6;
    localparam int STATUS_W = 3;
    localparam int PROTO_W  = 8;
    localparam int ADDR_W   = 32;
    localparam int CLASS_W  = 2;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 72;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_VER   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_IHL   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FRAGMENT  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BAD_CSUM  = 3'd6;

    // delivery classes
    localparam logic [CLASS_W-1:0] CLS_UDP = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_TCP = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_RAW = 2'd2;

    localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;
    localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;

    // header word positions
    localparam logic [POS_W-1:0] POS_VERSION = 5'd0;
    localparam logic [POS_W-1:0] POS_LENGTH  = 5'd1;
    localparam logic [POS_W-1:0] POS_FRAG    = 5'd3;
    localparam logic [POS_W-1:0] POS_PROTO   = 5'd4;
    localparam logic [POS_W-1:0] POS_SRC_HI  = 5'd6;
    localparam logic [POS_W-1:0] POS_SRC_LO  = 5'd7;

    localparam logic [WORD_W-1:0] MIN_BUFFER_BYTES = 16'd20;
    localparam logic [3:0]        IP_VERSION       = 4'd4;
    localparam logic [3:0]        MIN_IHL          = 4'd5;
    localparam logic [WORD_W-1:0] SUM_GOOD         = 16'hFFFF;

    typedef struct packed {
        logic [WORD_W-1:0] buffer_bytes;
        logic              first_word;
        logic [WORD_W-1:0] header_word;
    } in_word_t;

    typedef struct packed {
        logic [CLASS_W-1:0]  delivery_class;
        logic [ADDR_W-1:0]   source_address;
        logic [WORD_W-1:0]   total_length;
        logic [HBYTES_W-1:0] header_bytes;
        logic [PROTO_W-1:0]  protocol_number;
        logic [STATUS_W-1:0] status;
    } verdict_t;

    // ones-complement add with end-around carry
    function automatic logic [WORD_W-1:0] ones_add(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W:0]   s;
        logic [WORD_W:0]   f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[WORD_W-1:0]} + {{WORD_W{1'b0}}, s[WORD_W]};
        return f[WORD_W-1:0];
    endfunction

    function automatic logic [CLASS_W-1:0] class_of(input logic [PROTO_W-1:0] p);
        logic [CLASS_W-1:0] c;
        if (p == PROTO_UDP) begin
            c = CLS_UDP;
        end else if (p == PROTO_TCP) begin
            c = CLS_TCP;
        end else begin
            c = CLS_RAW;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/core/ipv4hv_in_stage.sv
// ----------------------------------------------------------------------------
// ipv4hv_in_stage
// input register of the validator, one item deep
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hv_in_stage (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [ipv4hv_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic                            s_tuser,
    input  wire logic                            advance,
    output logic                                 word_valid,
    output ipv4hv_pkg::in_word_t                 word
);

    logic                 valid_reg;
    logic                 valid_next;
    ipv4hv_pkg::in_word_t word_reg;

    // free when empty or when the held item moves on this cycle
    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            word_reg.header_word  <= s_tdata[15:0];
            word_reg.buffer_bytes <= s_tdata[31:16];
            word_reg.first_word   <= s_tuser;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

`default_nettype wire

### rtl/core/ipv4hv_check.sv
// ----------------------------------------------------------------------------
// ipv4hv_check
// per-packet parse state, header checks and checksum accumulation
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hv_check (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step,
    input  wire ipv4hv_pkg::in_word_t word,
    output logic                      emit,
    output ipv4hv_pkg::verdict_t      verdict
);

    logic [ipv4hv_pkg::POS_W-1:0]    word_position_reg;
    logic [ipv4hv_pkg::HWORDS_W-1:0] header_words_reg;
    logic [ipv4hv_pkg::WORD_W-1:0]   running_sum_reg;
    logic [ipv4hv_pkg::WORD_W-1:0]   buffer_size_reg;
    logic [ipv4hv_pkg::WORD_W-1:0]   total_length_reg;
    logic [ipv4hv_pkg::PROTO_W-1:0]  protocol_reg;
    logic [ipv4hv_pkg::ADDR_W-1:0]   source_reg;
    logic                            verdict_given_reg;

    logic [ipv4hv_pkg::POS_W-1:0]    word_position_next;
    logic [ipv4hv_pkg::HWORDS_W-1:0] header_words_next;
    logic [ipv4hv_pkg::WORD_W-1:0]   running_sum_next;
    logic [ipv4hv_pkg::WORD_W-1:0]   buffer_size_next;
    logic [ipv4hv_pkg::WORD_W-1:0]   total_length_next;
    logic [ipv4hv_pkg::PROTO_W-1:0]  protocol_next;
    logic [ipv4hv_pkg::ADDR_W-1:0]   source_next;

    logic                            first;
    logic                            active;
    logic [ipv4hv_pkg::WORD_W-1:0]   w;
    logic [ipv4hv_pkg::POS_W-1:0]    pos;
    logic [ipv4hv_pkg::WORD_W-1:0]   sum_base;
    logic [ipv4hv_pkg::WORD_W-1:0]   hdr_len16;
    logic [ipv4hv_pkg::POS_W:0]      pos_plus1;
    logic                            hit;
    logic [ipv4hv_pkg::STATUS_W-1:0] status;

    assign w      = word.header_word;
    assign first  = word.first_word;
    assign active = first || !verdict_given_reg;

    always_comb begin
        // a first word restarts the packet state
        pos               = first ? '0 : word_position_reg;
        sum_base          = first ? '0 : running_sum_reg;
        header_words_next = first ? '0 : header_words_reg;
        buffer_size_next  = first ? word.buffer_bytes : buffer_size_reg;
        total_length_next = first ? '0 : total_length_reg;
        protocol_next     = first ? '0 : protocol_reg;
        source_next       = first ? '0 : source_reg;
        running_sum_next  = ipv4hv_pkg::ones_add(sum_base, w);
        hit               = 1'b0;
        status            = ipv4hv_pkg::ST_OK;

        case (pos)
            ipv4hv_pkg::POS_VERSION: begin
                header_words_next = {w[11:8], 1'b0};
                if (buffer_size_next < ipv4hv_pkg::MIN_BUFFER_BYTES) begin
                    hit    = 1'b1;
                    status = ipv4hv_pkg::ST_TRUNCATED;
                end else if (w[15:12] != ipv4hv_pkg::IP_VERSION) begin
                    hit    = 1'b1;
                    status = ipv4hv_pkg::ST_BAD_VER;
                end else if (w[11:8] < ipv4hv_pkg::MIN_IHL) begin
                    hit    = 1'b1;
                    status = ipv4hv_pkg::ST_BAD_IHL;
                end
            end
            ipv4hv_pkg::POS_LENGTH: begin
                total_length_next = w;
            end
            ipv4hv_pkg::POS_PROTO: begin
                protocol_next = w[7:0];
            end
            ipv4hv_pkg::POS_SRC_HI: begin
                source_next = {w, 16'h0000};
            end
            ipv4hv_pkg::POS_SRC_LO: begin
                source_next = {source_next[31:16], w};
            end
            default: begin
            end
        endcase

        hdr_len16 = {10'd0, header_words_next, 1'b0};
        if (pos == ipv4hv_pkg::POS_LENGTH) begin
            if ((w < hdr_len16) || (w > buffer_size_next)) begin
                hit    = 1'b1;
                status = ipv4hv_pkg::ST_BAD_LEN;
            end
        end
        if (pos == ipv4hv_pkg::POS_FRAG) begin
            if (w[13:0] != 14'd0) begin
                hit    = 1'b1;
                status = ipv4hv_pkg::ST_FRAGMENT;
            end
        end

        // last header word closes the packet with the checksum verdict
        pos_plus1 = {1'b0, pos} + 6'd1;
        if (!hit && (header_words_next != '0) &&
            (pos_plus1 >= {1'b0, header_words_next})) begin
            hit    = 1'b1;
            status = (running_sum_next == ipv4hv_pkg::SUM_GOOD) ?
                     ipv4hv_pkg::ST_OK : ipv4hv_pkg::ST_BAD_CSUM;
        end

        word_position_next = hit ? pos : pos_plus1[ipv4hv_pkg::POS_W-1:0];
    end

    assign emit = step && active && hit;

    always_comb begin
        verdict.status          = status;
        verdict.protocol_number = protocol_next;
        verdict.header_bytes    = {header_words_next, 1'b0};
        verdict.total_length    = total_length_next;
        verdict.source_address  = source_next;
        verdict.delivery_class  = ipv4hv_pkg::class_of(protocol_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_position_reg <= '0;
            header_words_reg  <= '0;
            running_sum_reg   <= '0;
            buffer_size_reg   <= '0;
            total_length_reg  <= '0;
            protocol_reg      <= '0;
            source_reg        <= '0;
            verdict_given_reg <= 1'b1;
        end else if (step && active) begin
            word_position_reg <= word_position_next;
            header_words_reg  <= header_words_next;
            running_sum_reg   <= running_sum_next;
            buffer_size_reg   <= buffer_size_next;
            total_length_reg  <= total_length_next;
            protocol_reg      <= protocol_next;
            source_reg        <= source_next;
            verdict_given_reg <= hit;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ipv4hv_out_stage.sv
// ----------------------------------------------------------------------------
// ipv4hv_out_stage
// result register holding one verdict until the sink takes it
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hv_out_stage (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             load,
    input  wire logic                             load_valid,
    input  wire ipv4hv_pkg::verdict_t             verdict,
    output logic                                  open,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [ipv4hv_pkg::OUT_DATA_W-1:0]     m_tdata
);

    logic                 valid_reg;
    logic                 valid_next;
    ipv4hv_pkg::verdict_t verdict_reg;

    assign open = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = load_valid;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && load_valid) begin
            verdict_reg <= verdict;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0,
                       verdict_reg.delivery_class,
                       verdict_reg.source_address,
                       verdict_reg.total_length,
                       verdict_reg.header_bytes,
                       verdict_reg.protocol_number,
                       verdict_reg.status};

endmodule

`default_nettype wire

### rtl/core/ipv4_header_validator_unit.sv
// ----------------------------------------------------------------------------
// ipv4_header_validator_unit
// ipv4 receive header validator: one verdict per packet from a word stream
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata fields (lsb first)                         | tuser
//  --------+-----+--------------------------------------------------+-----------
//  s_      | in  | header_word[15:0], buffer_bytes[31:16]           | first_word
//  m_      | out | status[2:0], protocol_number[10:3],              | -
//          |     | header_bytes[16:11], total_length[32:17],        |
//          |     | source_address[64:33], delivery_class[66:65]     |
//
//  one item per cycle sustained while no untaken verdict blocks the result
//  register; an item waits in the input register and its verdict, if any, is
//  loaded into the result register once that register can take it
//  the rate is set by the single 16-bit ones-complement add and field checks
//  between the two registers
//  reset (aresetn low, synchronous) empties both registers and puts the parser
//  in the waiting-for-first-word state
//  when the result register holds an untaken verdict, the input register
//  still takes one more item; the stream stalls only once both are full
//
`default_nettype none

module ipv4_header_validator_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input items
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [ipv4hv_pkg::IN_DATA_W-1:0] s_tdata,   // header_word, buffer_bytes
    input  wire logic                             s_tuser,   // first_word
    // verdict items
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [ipv4hv_pkg::OUT_DATA_W-1:0]     m_tdata    // status, protocol_number,
                                                             // header_bytes, total_length,
                                                             // source_address,
                                                             // delivery_class, zero pad
);

    logic                 word_valid;
    ipv4hv_pkg::in_word_t word;
    logic                 out_open;
    logic                 step;
    logic                 emit;
    ipv4hv_pkg::verdict_t verdict;

    // the held word is processed when the result register can take its verdict
    assign step = word_valid && out_open;

    ipv4hv_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (step),
        .word_valid (word_valid),
        .word       (word)
    );

    // parse state, checks and checksum
    ipv4hv_check u_check (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .word    (word),
        .emit    (emit),
        .verdict (verdict)
    );

    // result register; loads an empty slot when a word passes without a verdict
    ipv4hv_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (step),
        .load_valid (emit),
        .verdict    (verdict),
        .open       (out_open),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

### rtl/core/ipv4hv_checker.sv
// ----------------------------------------------------------------------------
// ipv4hv_checker
// port-level checks of the validator's verdict stream
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hv_checker (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [ipv4hv_pkg::OUT_DATA_W-1:0] m_tdata
);

    logic [ipv4hv_pkg::STATUS_W-1:0] st;
    logic [ipv4hv_pkg::PROTO_W-1:0]  proto;
    logic [ipv4hv_pkg::HBYTES_W-1:0] hbytes;
    logic [ipv4hv_pkg::WORD_W-1:0]   tlen;
    logic [ipv4hv_pkg::CLASS_W-1:0]  cls;

    assign st     = m_tdata[2:0];
    assign proto  = m_tdata[10:3];
    assign hbytes = m_tdata[16:11];
    assign tlen   = m_tdata[32:17];
    assign cls    = m_tdata[66:65];

    // a held verdict does not change until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("verdict changed while stalled");

    // class follows the reported protocol
    a_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((proto == ipv4hv_pkg::PROTO_UDP && cls == ipv4hv_pkg::CLS_UDP) ||
                      (proto == ipv4hv_pkg::PROTO_TCP && cls == ipv4hv_pkg::CLS_TCP) ||
                      (proto != ipv4hv_pkg::PROTO_UDP && proto != ipv4hv_pkg::PROTO_TCP &&
                       cls == ipv4hv_pkg::CLS_RAW)))
        else $error("delivery class does not match protocol");

    // an accepted header passed the length checks
    a_ok_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == ipv4hv_pkg::ST_OK |->
            hbytes >= 6'd20 && hbytes[1:0] == 2'b00 && tlen >= {10'd0, hbytes})
        else $error("ok verdict with inconsistent lengths");

    // verdicts from the fragment check on carry consistent header and total lengths
    a_late_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st == ipv4hv_pkg::ST_FRAGMENT || st == ipv4hv_pkg::ST_BAD_CSUM) |->
            tlen >= {10'd0, hbytes} && hbytes >= 6'd20)
        else $error("late verdict without valid header length");

    // no undefined status code
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> st != 3'd7)
        else $error("undefined status code");

endmodule

bind ipv4_header_validator_unit ipv4hv_checker u_ipv4hv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
